>>> hdl/tcpq_pkg.sv
`timescale 1ns / 1ps

package tcpq_pkg;

	// Fixed field widths of the request and result channels
	localparam int FUNC_W     = 2;
	localparam int ACT_W      = 3;
	localparam int OUT_ID_W   = 16;
	localparam int OUT_TIME_W = 32;
	localparam int LIMIT_W    = 5;
	localparam int CNT_W      = 5;
	localparam int CTR_W      = 32;
	localparam int TOT_W      = 48;

	// Request function codes; every other code is a serve tick
	localparam logic [FUNC_W-1:0] FUNC_HIGH_REQ = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOW_REQ  = 2'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_ACCEPT      = 3'd0,
		ACT_REJECT      = 3'd1,
		ACT_HIGH_SERVED = 3'd2,
		ACT_LOW_SERVED  = 3'd3,
		ACT_IDLE        = 3'd4
	} action_t;

	typedef struct packed {
		logic hi_rej;
		logic lo_rej;
		logic hi_srv;
		logic lo_srv;
		logic idle;
	} stat_evt_t;

	typedef struct packed {
		logic [CTR_W-1:0] hi_rej;
		logic [CTR_W-1:0] lo_rej;
		logic [CTR_W-1:0] hi_srv;
		logic [CTR_W-1:0] lo_srv;
		logic [CTR_W-1:0] idle;
		logic [TOT_W-1:0] hi_wait;
		logic [TOT_W-1:0] lo_wait;
	} stats_t;

	typedef struct packed {
		action_t                 action;
		logic [OUT_ID_W-1:0]     served_id;
		logic [OUT_TIME_W-1:0]   wait_time;
		logic [CNT_W-1:0]        hi_cnt;
		logic [CNT_W-1:0]        lo_cnt;
		stats_t                  stats;
	} result_t;

endpackage

>>> hdl/tcpq_fifo.sv
`timescale 1ns / 1ps

module tcpq_fifo #(
	parameter int DEPTH  = 16,
	parameter int ID_W   = 16,
	parameter int TIME_W = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tcpq_pkg::LIMIT_W-1:0]  limit,
	input  logic                          push,
	input  logic                          pop,
	input  logic [ID_W-1:0]               push_id,
	input  logic [TIME_W-1:0]             push_time,
	output logic [ID_W-1:0]               head_id,
	output logic [TIME_W-1:0]             head_time,
	output logic [tcpq_pkg::CNT_W-1:0]    fill,
	output logic                          room
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENT_W = ID_W + TIME_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [ENT_W-1:0]            mem_q [DEPTH];
	logic [ENT_W-1:0]            head_data_q;
	logic [PTR_W-1:0]            head_q;
	logic [PTR_W-1:0]            tail_q;
	logic [tcpq_pkg::CNT_W-1:0]  fill_q;
	logic [PTR_W-1:0]            head_inc;
	logic [PTR_W-1:0]            tail_inc;
	logic [PTR_W-1:0]            head_nxt;
	logic [ENT_W-1:0]            wdata;

	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
	assign head_nxt = pop ? head_inc : head_q;
	assign wdata    = {push_id, push_time};

	assign room      = fill_q < limit;
	assign fill      = fill_q;
	assign head_id   = head_data_q[ENT_W-1:TIME_W];
	assign head_time = head_data_q[TIME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_inc;
			end
			if (pop) begin
				head_q <= head_inc;
			end
			fill_q <= fill_q + tcpq_pkg::CNT_W'(push) - tcpq_pkg::CNT_W'(pop);
		end
	end

	// Prefetch the next head; a push into an empty queue becomes the head directly
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= wdata;
		end
		if (push && (fill_q == '0)) begin
			head_data_q <= wdata;
		end else begin
			head_data_q <= mem_q[head_nxt];
		end
	end

endmodule

>>> hdl/tcpq_stats.sv
`timescale 1ns / 1ps

module tcpq_stats (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tcpq_pkg::stat_evt_t             evt,
	input  logic [tcpq_pkg::OUT_TIME_W-1:0] wait_val,
	output tcpq_pkg::stats_t                nxt
);

	tcpq_pkg::stats_t cur_q;

	// Advance each counter on its event; all wrap at their width
	always_comb begin
		nxt = cur_q;
		if (evt.hi_rej) begin
			nxt.hi_rej = cur_q.hi_rej + tcpq_pkg::CTR_W'(1);
		end
		if (evt.lo_rej) begin
			nxt.lo_rej = cur_q.lo_rej + tcpq_pkg::CTR_W'(1);
		end
		if (evt.hi_srv) begin
			nxt.hi_srv  = cur_q.hi_srv + tcpq_pkg::CTR_W'(1);
			nxt.hi_wait = cur_q.hi_wait + tcpq_pkg::TOT_W'(wait_val);
		end
		if (evt.lo_srv) begin
			nxt.lo_srv  = cur_q.lo_srv + tcpq_pkg::CTR_W'(1);
			nxt.lo_wait = cur_q.lo_wait + tcpq_pkg::TOT_W'(wait_val);
		end
		if (evt.idle) begin
			nxt.idle = cur_q.idle + tcpq_pkg::CTR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else begin
			cur_q <= nxt;
		end
	end

endmodule

>>> hdl/two_class_priority_queue_server.sv
`timescale 1ns / 1ps

// Two-class strict-priority queue server with tail drop. Each request carries
// a function code (high request, low request, or serve tick; the spare code
// also serves), a time stamp and an id. A request is queued in its class if
// that queue holds fewer entries than the queue limit, else it is rejected.
// A serve tick pops the high head if present, else the low head, else counts
// an idle tick, and reports the id and the wait (time now minus arrival,
// modulo 2^TIME_WIDTH). Every request yields exactly one result carrying the
// action, occupancies and all wrapping counters after the update. Rate: one
// request per cycle unless stalled, its result registered from a single pass
// from the queue head registers and counters through one subtract and
// accumulate into the result register. A two-entry output buffer lets the
// input keep flowing while a result waits; in_stall rises only when both
// entries hold results. The queue limit saturates to QUEUE_DEPTH (at most 31);
// the user must write it only while the block is idle; nothing enforces this.
module two_class_priority_queue_server #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TIME_WIDTH  = 32,
	parameter int ID_WIDTH    = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration
	input  logic                                   cfg_write,
	input  logic [tcpq_pkg::LIMIT_W-1:0]           cfg_data,
	// Request channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [tcpq_pkg::FUNC_W-1:0]            func,
	input  logic [tcpq_pkg::OUT_TIME_W-1:0]        time_now,
	input  logic [tcpq_pkg::OUT_ID_W-1:0]          plane_id,
	// Result channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [tcpq_pkg::ACT_W-1:0]             action,
	output logic [tcpq_pkg::OUT_ID_W-1:0]          served_id,
	output logic [tcpq_pkg::OUT_TIME_W-1:0]        wait_time,
	output logic [tcpq_pkg::CNT_W-1:0]             high_queue_count,
	output logic [tcpq_pkg::CNT_W-1:0]             low_queue_count,
	output logic [tcpq_pkg::CTR_W-1:0]             high_rejected,
	output logic [tcpq_pkg::CTR_W-1:0]             low_rejected,
	output logic [tcpq_pkg::CTR_W-1:0]             high_served,
	output logic [tcpq_pkg::CTR_W-1:0]             low_served,
	output logic [tcpq_pkg::CTR_W-1:0]             idle_ticks,
	output logic [tcpq_pkg::TOT_W-1:0]             high_wait_total,
	output logic [tcpq_pkg::TOT_W-1:0]             low_wait_total
);

	// Largest limit that the 5-bit register can hold and the queue can honor
	localparam int LIMIT_CAP = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;
	localparam int LIMIT_RST = (QUEUE_DEPTH < 16) ? QUEUE_DEPTH : 16;

	logic [tcpq_pkg::LIMIT_W-1:0]  limit_q;

	logic                          acc;
	logic                          is_hreq;
	logic                          is_lreq;
	logic                          is_srv;
	logic [TIME_WIDTH-1:0]         t_now;
	logic [ID_WIDTH-1:0]           req_id;

	logic                          hi_push;
	logic                          lo_push;
	logic                          hi_pop;
	logic                          lo_pop;
	logic                          hi_room;
	logic                          lo_room;
	logic [tcpq_pkg::CNT_W-1:0]    hi_fill;
	logic [tcpq_pkg::CNT_W-1:0]    lo_fill;
	logic [ID_WIDTH-1:0]           hi_head_id;
	logic [ID_WIDTH-1:0]           lo_head_id;
	logic [TIME_WIDTH-1:0]         hi_head_time;
	logic [TIME_WIDTH-1:0]         lo_head_time;

	logic                          hi_avail;
	logic [ID_WIDTH-1:0]           srv_id;
	logic [TIME_WIDTH-1:0]         srv_wait;
	logic [tcpq_pkg::OUT_TIME_W-1:0] srv_wait_ext;

	tcpq_pkg::stat_evt_t           evt;
	tcpq_pkg::stats_t              stats_nxt;
	tcpq_pkg::result_t             res;

	tcpq_pkg::result_t             out_q;
	tcpq_pkg::result_t             skid_q;
	logic                          out_valid_q;
	logic                          skid_valid_q;
	logic                          take;

	// Hold the effective limit, saturated to the queue depth at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tcpq_pkg::LIMIT_W'(LIMIT_RST);
		end else if (cfg_write) begin
			if (int'(cfg_data) > LIMIT_CAP) begin
				limit_q <= tcpq_pkg::LIMIT_W'(LIMIT_CAP);
			end else begin
				limit_q <= cfg_data;
			end
		end
	end

	// Decode the request; the spare function code serves like a tick
	assign acc     = in_valid && !in_stall;
	assign is_hreq = (func == tcpq_pkg::FUNC_HIGH_REQ);
	assign is_lreq = (func == tcpq_pkg::FUNC_LOW_REQ);
	assign is_srv  = !is_hreq && !is_lreq;
	assign t_now   = time_now[TIME_WIDTH-1:0];
	assign req_id  = plane_id[ID_WIDTH-1:0];

	// Strict priority: low is served only when high is empty
	assign hi_avail = (hi_fill != '0);
	assign hi_push  = acc && is_hreq && hi_room;
	assign lo_push  = acc && is_lreq && lo_room;
	assign hi_pop   = acc && is_srv && hi_avail;
	assign lo_pop   = acc && is_srv && !hi_avail && (lo_fill != '0);

	tcpq_fifo #(
		.DEPTH  (QUEUE_DEPTH),
		.ID_W   (ID_WIDTH),
		.TIME_W (TIME_WIDTH)
	) u_hi_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit_q),
		.push      (hi_push),
		.pop       (hi_pop),
		.push_id   (req_id),
		.push_time (t_now),
		.head_id   (hi_head_id),
		.head_time (hi_head_time),
		.fill      (hi_fill),
		.room      (hi_room)
	);

	tcpq_fifo #(
		.DEPTH  (QUEUE_DEPTH),
		.ID_W   (ID_WIDTH),
		.TIME_W (TIME_WIDTH)
	) u_lo_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit_q),
		.push      (lo_push),
		.pop       (lo_pop),
		.push_id   (req_id),
		.push_time (t_now),
		.head_id   (lo_head_id),
		.head_time (lo_head_time),
		.fill      (lo_fill),
		.room      (lo_room)
	);

	// Wait of whichever head gets served; wraps at the time width
	assign srv_id       = hi_avail ? hi_head_id : lo_head_id;
	assign srv_wait     = t_now - (hi_avail ? hi_head_time : lo_head_time);
	assign srv_wait_ext = tcpq_pkg::OUT_TIME_W'(srv_wait);

	always_comb begin
		evt        = '0;
		evt.hi_rej = acc && is_hreq && !hi_room;
		evt.lo_rej = acc && is_lreq && !lo_room;
		evt.hi_srv = hi_pop;
		evt.lo_srv = lo_pop;
		evt.idle   = acc && is_srv && !hi_avail && (lo_fill == '0);
	end

	tcpq_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.wait_val (srv_wait_ext),
		.nxt      (stats_nxt)
	);

	// Assemble the result from the state after this request
	always_comb begin
		res           = '0;
		res.stats     = stats_nxt;
		res.hi_cnt    = hi_fill + tcpq_pkg::CNT_W'(hi_push) - tcpq_pkg::CNT_W'(hi_pop);
		res.lo_cnt    = lo_fill + tcpq_pkg::CNT_W'(lo_push) - tcpq_pkg::CNT_W'(lo_pop);
		if (is_hreq || is_lreq) begin
			res.served_id = tcpq_pkg::OUT_ID_W'(req_id);
			if ((is_hreq && hi_room) || (is_lreq && lo_room)) begin
				res.action = tcpq_pkg::ACT_ACCEPT;
			end else begin
				res.action = tcpq_pkg::ACT_REJECT;
			end
		end else if (hi_avail) begin
			res.action    = tcpq_pkg::ACT_HIGH_SERVED;
			res.served_id = tcpq_pkg::OUT_ID_W'(srv_id);
			res.wait_time = srv_wait_ext;
		end else if (lo_fill != '0) begin
			res.action    = tcpq_pkg::ACT_LOW_SERVED;
			res.served_id = tcpq_pkg::OUT_ID_W'(srv_id);
			res.wait_time = srv_wait_ext;
		end else begin
			res.action = tcpq_pkg::ACT_IDLE;
		end
	end

	// Two-entry output buffer: the output register plus a skid entry.
	// Stall the input only when the skid entry is occupied.
	assign take     = out_valid_q && !out_stall;
	assign in_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (acc) begin
				if (out_valid_q && !take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (out_valid_q && !take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign action           = out_q.action;
	assign served_id        = out_q.served_id;
	assign wait_time        = out_q.wait_time;
	assign high_queue_count = out_q.hi_cnt;
	assign low_queue_count  = out_q.lo_cnt;
	assign high_rejected    = out_q.stats.hi_rej;
	assign low_rejected     = out_q.stats.lo_rej;
	assign high_served      = out_q.stats.hi_srv;
	assign low_served       = out_q.stats.lo_srv;
	assign idle_ticks       = out_q.stats.idle;
	assign high_wait_total  = out_q.stats.hi_wait;
	assign low_wait_total   = out_q.stats.lo_wait;

	// The skid entry is only ever filled behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output entry");

	// A serve with high entries pending drops the high fill by one
	a_high_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_srv && hi_avail) |=>
		(hi_fill == $past(hi_fill) - tcpq_pkg::CNT_W'(1)))
		else $error("high queue fill did not drop on serve");

	// A low request with room grows the low queue and leaves the high queue alone
	a_low_push: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_lreq && lo_room) |=>
		((lo_fill == $past(lo_fill) + tcpq_pkg::CNT_W'(1)) && $stable(hi_fill)))
		else $error("low request with room not queued");

	// Occupancy never exceeds the saturated limit range
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(hi_fill) <= LIMIT_CAP) && (int'(lo_fill) <= LIMIT_CAP))
		else $error("queue fill beyond depth");

endmodule
